@@ sv/c8core_pkg.sv @@
// shared constants, types and helper functions of the chip8 instruction core
package c8core_pkg;

  localparam int unsigned MEM_DEPTH   = 4096;
  localparam int unsigned MEM_AW      = $clog2(MEM_DEPTH);
  localparam int unsigned SCREEN_W    = 64;
  localparam int unsigned SCREEN_H    = 32;
  localparam int unsigned XW          = $clog2(SCREEN_W);
  localparam int unsigned YW          = $clog2(SCREEN_H);
  localparam int unsigned PIXELS      = SCREEN_W * SCREEN_H;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SPW         = $clog2(STACK_DEPTH);

  localparam logic [11:0] PC_RST   = 12'd512;
  localparam logic [11:0] FONT_RST = 12'd80;

  localparam int unsigned CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FONT  = 2'd1;

  // opcode groups
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEK  = 4'h3;
  localparam logic [3:0] OP_SNEK = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDK  = 4'h6;
  localparam logic [3:0] OP_ADDK = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GDLY = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDLY = 8'h15;
  localparam logic [7:0] MISC_SSND = 8'h18;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STR  = 8'h55;
  localparam logic [7:0] MISC_LDR  = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_PIXEL = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    K_SIMPLE,
    K_FLAG,
    K_DRAW,
    K_BCD,
    K_STORE,
    K_LOAD
  } kind_e;

  typedef enum logic [1:0] {
    MA_REQ,
    MA_PC,
    MA_PC1,
    MA_IDX
  } maddr_e;

  typedef enum logic [1:0] {
    MW_REQ,
    MW_BCD,
    MW_REG
  } mwdat_e;

  typedef enum logic [1:0] {
    RW_EXEC,
    RW_FLAG,
    RW_LOAD
  } rwsel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEM_WR,
    S_MEM_RD,
    S_PIX_RD,
    S_FETCH_HI,
    S_FETCH_LO,
    S_DECODE,
    S_EXEC,
    S_VF_WR,
    S_DRAW_RD,
    S_DRAW_WR,
    S_BCD,
    S_STORE_RD,
    S_STORE_WR,
    S_LOAD_RD,
    S_LOAD_WR,
    S_TICK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic   in_load;
    logic   mem_rd;
    logic   mem_wr;
    maddr_e mem_asel;
    mwdat_e mem_wsel;
    logic   fetch_hi;
    logic   fetch_lo;
    logic   reg_rd_op;
    logic   reg_rd_cnt;
    logic   reg_wr;
    rwsel_e reg_wsel;
    logic   exec;
    logic   fb_rd_pix;
    logic   draw_rd;
    logic   draw_wr;
    logic   cnt_inc;
    logic   tick;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  cnt_last;
    logic  bcd_last;
    logic  draw_end;
  } sts_t;

  typedef struct packed {
    logic [YW-1:0] row;
    logic [XW-1:0] col;
  } pix_t;

  typedef struct packed {
    logic [7:0] hun;
    logic [7:0] ten;
    logic [7:0] one;
  } bcd_t;

  // address modulo memory depth by compare and subtract
  function automatic logic [MEM_AW-1:0] mem_wrap(input logic [16:0] a);
    logic [21:0] r;
    r = 22'(a);
    for (int k = 4; k >= 0; k--) begin
      if (r >= 22'(MEM_DEPTH << k)) r = r - 22'(MEM_DEPTH << k);
    end
    return r[MEM_AW-1:0];
  endfunction

  // byte modulo screen size, quotient stays below eight
  function automatic logic [7:0] scr_mod(input logic [7:0] v, input int unsigned m);
    logic [10:0] r;
    r = 11'(v);
    for (int k = 2; k >= 0; k--) begin
      if (r >= 11'(m << k)) r = r - 11'(m << k);
    end
    return r[7:0];
  endfunction

  // pixel index into row and column, index below PIXELS
  function automatic pix_t pix_split(input logic [11:0] a);
    logic [13:0]   r;
    logic [YW-1:0] q;
    pix_t          p;
    r = 14'(a);
    q = '0;
    for (int k = YW - 1; k >= 0; k--) begin
      if (r >= 14'(SCREEN_W << k)) begin
        r    = r - 14'(SCREEN_W << k);
        q[k] = 1'b1;
      end
    end
    p.row = q;
    p.col = r[XW-1:0];
    return p;
  endfunction

  function automatic bcd_t bcd_split(input logic [7:0] v);
    logic [7:0] r;
    logic [3:0] t;
    bcd_t       b;
    r = v;
    b.hun = 8'd0;
    if (r >= 8'd200) begin
      r = r - 8'd200;
      b.hun = 8'd2;
    end else if (r >= 8'd100) begin
      r = r - 8'd100;
      b.hun = 8'd1;
    end
    t = '0;
    for (int k = 3; k >= 0; k--) begin
      if (r >= 8'(10 << k)) begin
        r    = r - 8'(10 << k);
        t[k] = 1'b1;
      end
    end
    b.ten = {4'd0, t};
    b.one = r;
    return b;
  endfunction

  // sprite byte placed at column x0, clipped at the right edge
  function automatic logic [SCREEN_W-1:0] sprite_row(input logic [7:0] bits,
                                                     input logic [XW-1:0] x0);
    logic [SCREEN_W-1:0] m;
    int                  d;
    m = '0;
    for (int c = 0; c < SCREEN_W; c++) begin
      d = c - int'(x0);
      if (d >= 0 && d < 8) m[c] = bits[7-d];
    end
    return m;
  endfunction

endpackage

@@ sv/c8core_if.sv @@
// request, response and configuration channel interfaces
interface c8core_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] address;
  logic [7:0]  write_byte;
  logic [15:0] keys_down;
  logic [7:0]  random_byte;
  modport source (output valid, req_type, address, write_byte, keys_down, random_byte,
                  input ready);
  modport sink (input valid, req_type, address, write_byte, keys_down, random_byte,
                output ready);
endinterface

interface c8core_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [15:0] fetched_opcode;
  logic [11:0] next_pc;
  logic        sound_on;
  logic        waiting_key;
  modport source (output valid, read_value, fetched_opcode, next_pc, sound_on, waiting_key,
                  input ready);
  modport sink (input valid, read_value, fetched_opcode, next_pc, sound_on, waiting_key,
                output ready);
endinterface

interface c8core_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [c8core_pkg::CFG_IW-1:0]   index;
  logic [11:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/c8core_dp.sv @@
// datapath: memories, register file, frame buffer, instruction execute
module c8core_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  c8core_pkg::cmd_t              cmd_i,
  output c8core_pkg::sts_t              sts_o,
  input  logic [1:0]                    req_type_i,
  input  logic [11:0]                   address_i,
  input  logic [7:0]                    write_byte_i,
  input  logic [15:0]                   keys_down_i,
  input  logic [7:0]                    random_byte_i,
  input  logic                          cfg_we_i,
  input  logic [c8core_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [11:0]                   cfg_data_i,
  output logic [7:0]                    read_value_o,
  output logic [15:0]                   fetched_opcode_o,
  output logic [11:0]                   next_pc_o,
  output logic                          sound_on_o,
  output logic                          waiting_key_o
);

  // latched request
  c8core_pkg::req_e req_q;
  logic [11:0] addr_q;
  logic [7:0]  wbyte_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;

  logic [7:0]  hi_q;
  logic [15:0] op_q;
  logic [11:0] pc_q;
  logic [15:0] idx_q;
  logic [c8core_pkg::SPW-1:0] sp_q;
  logic [11:0] stack_q [c8core_pkg::STACK_DEPTH];
  logic [7:0]  dly_q, snd_q;
  logic [11:0] font_q;
  logic [3:0]  cnt_q;
  logic        flag_q;
  logic        wait_q;

  // main memory
  logic [7:0] mem [c8core_pkg::MEM_DEPTH];
  logic [7:0] mrd_q;
  logic [16:0] mbase, msum;
  logic [c8core_pkg::MEM_AW-1:0] maddr;
  logic [7:0] mwdata;

  // register file, two registered read ports
  logic [7:0]  rf [16];
  logic [15:0] rf_vld_q;
  logic [7:0]  ra_q, rb_q;
  logic        ra_v_q, rb_v_q;
  logic [3:0]  ra_addr, rb_addr;
  logic        rd_a, rd_b;
  logic [7:0]  vx, vy;
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [7:0]  rf_wd;

  // frame buffer, one row per entry
  logic [c8core_pkg::SCREEN_W-1:0] fb_mem [c8core_pkg::SCREEN_H];
  logic [c8core_pkg::SCREEN_H-1:0] fb_vld_q;
  logic [c8core_pkg::SCREEN_W-1:0] fb_rd_q;
  logic                            fb_rv_q;
  logic [c8core_pkg::SCREEN_W-1:0] fb_old, fb_mask;
  logic [c8core_pkg::YW-1:0]       fb_raddr;

  c8core_pkg::pix_t pix;
  logic             pix_in;

  logic [c8core_pkg::XW-1:0] x0;
  logic [c8core_pkg::YW-1:0] y0;
  logic [c8core_pkg::YW:0]   y_cur;
  c8core_pkg::bcd_t          bcd;

  // execute results
  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_kk;
  logic [11:0] op_nnn;
  logic [11:0] pc_nx;
  logic [15:0] idx_nx;
  logic [c8core_pkg::SPW-1:0] sp_nx;
  logic        stk_we;
  logic        dly_we, snd_we;
  logic        fb_clr;
  logic        wait_nx;
  logic        ex_we;
  logic [3:0]  ex_wa;
  logic [7:0]  ex_wd;
  logic        ex_flag;
  logic [8:0]  sum9;
  logic [3:0]  key_idx;
  c8core_pkg::kind_e kind;

  assign op_x   = op_q[11:8];
  assign op_y   = op_q[7:4];
  assign op_n   = op_q[3:0];
  assign op_kk  = op_q[7:0];
  assign op_nnn = op_q[11:0];

  assign vx = ra_v_q ? ra_q : 8'd0;
  assign vy = rb_v_q ? rb_q : 8'd0;

  // memory address and write data
  always_comb begin
    case (cmd_i.mem_asel)
      c8core_pkg::MA_REQ: msum = {5'd0, addr_q};
      c8core_pkg::MA_PC:  msum = {5'd0, pc_q};
      c8core_pkg::MA_PC1: msum = {5'd0, pc_q} + 17'd1;
      c8core_pkg::MA_IDX: msum = {1'b0, idx_q} + {13'd0, cnt_q};
      default:            msum = {5'd0, addr_q};
    endcase
  end
  assign mbase = msum;
  assign maddr = c8core_pkg::mem_wrap(mbase);

  assign bcd = c8core_pkg::bcd_split(vx);

  always_comb begin
    case (cmd_i.mem_wsel)
      c8core_pkg::MW_REQ: mwdata = wbyte_q;
      c8core_pkg::MW_BCD: mwdata = (cnt_q == 4'd0) ? bcd.hun :
                                   (cnt_q == 4'd1) ? bcd.ten : bcd.one;
      c8core_pkg::MW_REG: mwdata = vx;
      default:            mwdata = wbyte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[maddr] <= mwdata;
    if (cmd_i.mem_rd) mrd_q <= mem[maddr];
  end

  // register file ports
  always_comb begin
    ra_addr = cmd_i.reg_rd_cnt ? cnt_q : hi_q[3:0];
    rb_addr = (hi_q[7:4] == c8core_pkg::OP_JPV0) ? 4'd0 : mrd_q[7:4];
    rd_a    = cmd_i.reg_rd_op | cmd_i.reg_rd_cnt;
    rd_b    = cmd_i.reg_rd_op;
  end

  always_comb begin
    case (cmd_i.reg_wsel)
      c8core_pkg::RW_EXEC: begin
        rf_we = cmd_i.reg_wr & ex_we;
        rf_wa = ex_wa;
        rf_wd = ex_wd;
      end
      c8core_pkg::RW_FLAG: begin
        rf_we = cmd_i.reg_wr;
        rf_wa = c8core_pkg::REG_VF;
        rf_wd = {7'd0, flag_q};
      end
      c8core_pkg::RW_LOAD: begin
        rf_we = cmd_i.reg_wr;
        rf_wa = cnt_q;
        rf_wd = mrd_q;
      end
      default: begin
        rf_we = 1'b0;
        rf_wa = ex_wa;
        rf_wd = ex_wd;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rd_a) ra_q <= rf[ra_addr];
    if (rd_b) rb_q <= rf[rb_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      ra_v_q   <= 1'b0;
      rb_v_q   <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (rd_a) ra_v_q <= rf_vld_q[ra_addr];
      if (rd_b) rb_v_q <= rf_vld_q[rb_addr];
    end
  end

  // frame buffer
  assign pix    = c8core_pkg::pix_split(addr_q);
  assign pix_in = {1'b0, addr_q} < 13'(c8core_pkg::PIXELS);

  assign x0    = c8core_pkg::XW'(c8core_pkg::scr_mod(vx, c8core_pkg::SCREEN_W));
  assign y0    = c8core_pkg::YW'(c8core_pkg::scr_mod(vy, c8core_pkg::SCREEN_H));
  assign y_cur = {1'b0, y0} + (c8core_pkg::YW+1)'(cnt_q);

  assign fb_raddr = cmd_i.fb_rd_pix ? pix.row : y_cur[c8core_pkg::YW-1:0];
  assign fb_old   = fb_rv_q ? fb_rd_q : '0;
  assign fb_mask  = c8core_pkg::sprite_row(mrd_q, x0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_wr) fb_mem[y_cur[c8core_pkg::YW-1:0]] <= fb_old ^ fb_mask;
    if (cmd_i.fb_rd_pix || cmd_i.draw_rd) fb_rd_q <= fb_mem[fb_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_vld_q <= '0;
      fb_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.exec && fb_clr) fb_vld_q <= '0;
      if (cmd_i.draw_wr) fb_vld_q[y_cur[c8core_pkg::YW-1:0]] <= 1'b1;
      if (cmd_i.fb_rd_pix || cmd_i.draw_rd) fb_rv_q <= fb_vld_q[fb_raddr];
    end
  end

  // instruction kind
  always_comb begin
    kind = c8core_pkg::K_SIMPLE;
    case (op_q[15:12])
      c8core_pkg::OP_DRW: kind = c8core_pkg::K_DRAW;
      c8core_pkg::OP_ALU: begin
        if (op_n inside {c8core_pkg::ALU_ADD, c8core_pkg::ALU_SUB, c8core_pkg::ALU_SHR,
                         c8core_pkg::ALU_SBN, c8core_pkg::ALU_SHL})
          kind = c8core_pkg::K_FLAG;
      end
      c8core_pkg::OP_MISC: begin
        if (op_kk == c8core_pkg::MISC_BCD) kind = c8core_pkg::K_BCD;
        else if (op_kk == c8core_pkg::MISC_STR) kind = c8core_pkg::K_STORE;
        else if (op_kk == c8core_pkg::MISC_LDR) kind = c8core_pkg::K_LOAD;
      end
      default: kind = c8core_pkg::K_SIMPLE;
    endcase
  end

  // lowest pressed key
  always_comb begin
    key_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_q[i]) key_idx = 4'(i);
    end
  end

  // combinational execute
  always_comb begin
    pc_nx   = pc_q;
    idx_nx  = idx_q;
    sp_nx   = sp_q;
    stk_we  = 1'b0;
    dly_we  = 1'b0;
    snd_we  = 1'b0;
    fb_clr  = 1'b0;
    wait_nx = 1'b0;
    ex_we   = 1'b0;
    ex_wa   = op_x;
    ex_wd   = 8'd0;
    ex_flag = 1'b0;
    sum9    = {1'b0, vx} + {1'b0, vy};
    case (op_q[15:12])
      c8core_pkg::OP_SYS: begin
        if (op_q == c8core_pkg::OP_CLS) fb_clr = 1'b1;
        else if (op_q == c8core_pkg::OP_RET) begin
          sp_nx = sp_q - 1'b1;
          pc_nx = stack_q[sp_q - 1'b1];
        end
      end
      c8core_pkg::OP_JP: pc_nx = op_nnn;
      c8core_pkg::OP_CALL: begin
        stk_we = 1'b1;
        sp_nx  = sp_q + 1'b1;
        pc_nx  = op_nnn;
      end
      c8core_pkg::OP_SEK:  if (vx == op_kk) pc_nx = pc_q + 12'd2;
      c8core_pkg::OP_SNEK: if (vx != op_kk) pc_nx = pc_q + 12'd2;
      c8core_pkg::OP_SER:  if (vx == vy) pc_nx = pc_q + 12'd2;
      c8core_pkg::OP_SNER: if (vx != vy) pc_nx = pc_q + 12'd2;
      c8core_pkg::OP_LDK: begin
        ex_we = 1'b1;
        ex_wd = op_kk;
      end
      c8core_pkg::OP_ADDK: begin
        ex_we = 1'b1;
        ex_wd = vx + op_kk;
      end
      c8core_pkg::OP_ALU: begin
        ex_we = 1'b1;
        case (op_n)
          c8core_pkg::ALU_MOV: ex_wd = vy;
          c8core_pkg::ALU_OR:  ex_wd = vx | vy;
          c8core_pkg::ALU_AND: ex_wd = vx & vy;
          c8core_pkg::ALU_XOR: ex_wd = vx ^ vy;
          c8core_pkg::ALU_ADD: begin
            ex_wd   = sum9[7:0];
            ex_flag = sum9[8];
          end
          c8core_pkg::ALU_SUB: begin
            ex_wd   = vx - vy;
            ex_flag = vx >= vy;
          end
          c8core_pkg::ALU_SHR: begin
            ex_wd   = {1'b0, vx[7:1]};
            ex_flag = vx[0];
          end
          c8core_pkg::ALU_SBN: begin
            ex_wd   = vy - vx;
            ex_flag = vy >= vx;
          end
          c8core_pkg::ALU_SHL: begin
            ex_wd   = {vx[6:0], 1'b0};
            ex_flag = vx[7];
          end
          default: ex_we = 1'b0;
        endcase
      end
      c8core_pkg::OP_LDI:  idx_nx = {4'd0, op_nnn};
      // port b holds v0 for this opcode
      c8core_pkg::OP_JPV0: pc_nx = op_nnn + {4'd0, vy};
      c8core_pkg::OP_RND: begin
        ex_we = 1'b1;
        ex_wd = rnd_q & op_kk;
      end
      c8core_pkg::OP_DRW: ex_flag = 1'b0;
      c8core_pkg::OP_KEY: begin
        if (op_kk == c8core_pkg::KEY_SKP && keys_q[vx[3:0]]) pc_nx = pc_q + 12'd2;
        else if (op_kk == c8core_pkg::KEY_SKNP && !keys_q[vx[3:0]]) pc_nx = pc_q + 12'd2;
      end
      c8core_pkg::OP_MISC: begin
        case (op_kk)
          c8core_pkg::MISC_GDLY: begin
            ex_we = 1'b1;
            ex_wd = dly_q;
          end
          c8core_pkg::MISC_WKEY: begin
            if (|keys_q) begin
              ex_we = 1'b1;
              ex_wd = {4'd0, key_idx};
            end else begin
              pc_nx   = pc_q - 12'd2;
              wait_nx = 1'b1;
            end
          end
          c8core_pkg::MISC_SDLY: dly_we = 1'b1;
          c8core_pkg::MISC_SSND: snd_we = 1'b1;
          c8core_pkg::MISC_ADDI: idx_nx = idx_q + {8'd0, vx};
          c8core_pkg::MISC_FONT: idx_nx = {4'd0, font_q} + {6'd0, vx, 2'd0} + {8'd0, vx};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequential state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= c8core_pkg::REQ_WRITE;
      pc_q   <= c8core_pkg::PC_RST;
      idx_q  <= '0;
      sp_q   <= '0;
      dly_q  <= '0;
      snd_q  <= '0;
      font_q <= c8core_pkg::FONT_RST;
      cnt_q  <= '0;
      flag_q <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      // start address only matters at reset, writes to it change nothing
      if (cfg_we_i && cfg_index_i == c8core_pkg::CFG_FONT) font_q <= cfg_data_i;
      if (cmd_i.in_load) begin
        req_q  <= c8core_pkg::req_e'(req_type_i);
        wait_q <= 1'b0;
      end
      if (cmd_i.fetch_lo) pc_q <= pc_q + 12'd2;
      if (cmd_i.exec) begin
        pc_q   <= pc_nx;
        idx_q  <= idx_nx;
        sp_q   <= sp_nx;
        wait_q <= wait_nx;
        flag_q <= ex_flag;
        cnt_q  <= '0;
        if (dly_we) dly_q <= vx;
        if (snd_we) snd_q <= vx;
      end
      if (cmd_i.draw_wr) flag_q <= flag_q | (|(fb_old & fb_mask));
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 4'd1;
      if (cmd_i.tick) begin
        if (dly_q != 8'd0) dly_q <= dly_q - 8'd1;
        if (snd_q != 8'd0) snd_q <= snd_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      addr_q  <= address_i;
      wbyte_q <= write_byte_i;
      keys_q  <= keys_down_i;
      rnd_q   <= random_byte_i;
    end
    if (cmd_i.fetch_hi) hi_q <= mrd_q;
    if (cmd_i.fetch_lo) op_q <= {hi_q, mrd_q};
    if (cmd_i.in_load && req_type_i != c8core_pkg::REQ_RUN) op_q <= '0;
    if (cmd_i.exec && stk_we) stack_q[sp_q] <= pc_q;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (req_q)
        c8core_pkg::REQ_READ:  read_value_o <= mrd_q;
        c8core_pkg::REQ_PIXEL: read_value_o <= {7'd0, pix_in & fb_rv_q & fb_rd_q[pix.col]};
        default:               read_value_o <= 8'd0;
      endcase
      fetched_opcode_o <= op_q;
      next_pc_o        <= pc_q;
      sound_on_o       <= snd_q != 8'd0;
      waiting_key_o    <= wait_q;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.kind     = kind;
    sts_o.cnt_last = cnt_q == op_x;
    sts_o.bcd_last = cnt_q == 4'd2;
    sts_o.draw_end = (cnt_q == op_n) || (y_cur >= (c8core_pkg::YW+1)'(c8core_pkg::SCREEN_H));
  end

endmodule

@@ sv/c8core_ctrl.sv @@
// controller state machine sequencing requests and instruction steps
module c8core_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  c8core_pkg::sts_t sts_i,
  output c8core_pkg::cmd_t cmd_o
);

  c8core_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;
  logic out_free;

  assign in_ready_o  = state_q == c8core_pkg::S_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      c8core_pkg::S_IDLE: begin
        if (in_acc) begin
          case (c8core_pkg::req_e'(req_type_i))
            c8core_pkg::REQ_WRITE: state_d = c8core_pkg::S_MEM_WR;
            c8core_pkg::REQ_RUN:   state_d = c8core_pkg::S_FETCH_HI;
            c8core_pkg::REQ_READ:  state_d = c8core_pkg::S_MEM_RD;
            c8core_pkg::REQ_PIXEL: state_d = c8core_pkg::S_PIX_RD;
            default:               state_d = c8core_pkg::S_IDLE;
          endcase
        end
      end
      c8core_pkg::S_MEM_WR, c8core_pkg::S_MEM_RD, c8core_pkg::S_PIX_RD:
        state_d = c8core_pkg::S_DONE;
      c8core_pkg::S_FETCH_HI: state_d = c8core_pkg::S_FETCH_LO;
      c8core_pkg::S_FETCH_LO: state_d = c8core_pkg::S_DECODE;
      c8core_pkg::S_DECODE:   state_d = c8core_pkg::S_EXEC;
      c8core_pkg::S_EXEC: begin
        case (sts_i.kind)
          c8core_pkg::K_FLAG:  state_d = c8core_pkg::S_VF_WR;
          c8core_pkg::K_DRAW:  state_d = c8core_pkg::S_DRAW_RD;
          c8core_pkg::K_BCD:   state_d = c8core_pkg::S_BCD;
          c8core_pkg::K_STORE: state_d = c8core_pkg::S_STORE_RD;
          c8core_pkg::K_LOAD:  state_d = c8core_pkg::S_LOAD_RD;
          default:             state_d = c8core_pkg::S_TICK;
        endcase
      end
      c8core_pkg::S_VF_WR: state_d = c8core_pkg::S_TICK;
      c8core_pkg::S_DRAW_RD:
        state_d = sts_i.draw_end ? c8core_pkg::S_VF_WR : c8core_pkg::S_DRAW_WR;
      c8core_pkg::S_DRAW_WR: state_d = c8core_pkg::S_DRAW_RD;
      c8core_pkg::S_BCD:
        if (sts_i.bcd_last) state_d = c8core_pkg::S_TICK;
      c8core_pkg::S_STORE_RD: state_d = c8core_pkg::S_STORE_WR;
      c8core_pkg::S_STORE_WR:
        state_d = sts_i.cnt_last ? c8core_pkg::S_TICK : c8core_pkg::S_STORE_RD;
      c8core_pkg::S_LOAD_RD: state_d = c8core_pkg::S_LOAD_WR;
      c8core_pkg::S_LOAD_WR:
        state_d = sts_i.cnt_last ? c8core_pkg::S_TICK : c8core_pkg::S_LOAD_RD;
      c8core_pkg::S_TICK: state_d = c8core_pkg::S_DONE;
      c8core_pkg::S_DONE:
        if (out_free) state_d = c8core_pkg::S_IDLE;
      default: state_d = c8core_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      c8core_pkg::S_IDLE: cmd_o.in_load = in_acc;
      c8core_pkg::S_MEM_WR: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_REQ;
        cmd_o.mem_wsel = c8core_pkg::MW_REQ;
      end
      c8core_pkg::S_MEM_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_REQ;
      end
      c8core_pkg::S_PIX_RD: cmd_o.fb_rd_pix = 1'b1;
      c8core_pkg::S_FETCH_HI: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_PC;
      end
      c8core_pkg::S_FETCH_LO: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_PC1;
        cmd_o.fetch_hi = 1'b1;
      end
      c8core_pkg::S_DECODE: begin
        cmd_o.fetch_lo  = 1'b1;
        cmd_o.reg_rd_op = 1'b1;
      end
      c8core_pkg::S_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.reg_wr   = 1'b1;
        cmd_o.reg_wsel = c8core_pkg::RW_EXEC;
      end
      c8core_pkg::S_VF_WR: begin
        cmd_o.reg_wr   = 1'b1;
        cmd_o.reg_wsel = c8core_pkg::RW_FLAG;
      end
      c8core_pkg::S_DRAW_RD: begin
        cmd_o.mem_rd   = !sts_i.draw_end;
        cmd_o.mem_asel = c8core_pkg::MA_IDX;
        cmd_o.draw_rd  = !sts_i.draw_end;
      end
      c8core_pkg::S_DRAW_WR: begin
        cmd_o.draw_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      c8core_pkg::S_BCD: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_IDX;
        cmd_o.mem_wsel = c8core_pkg::MW_BCD;
        cmd_o.cnt_inc  = 1'b1;
      end
      c8core_pkg::S_STORE_RD: cmd_o.reg_rd_cnt = 1'b1;
      c8core_pkg::S_STORE_WR: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_IDX;
        cmd_o.mem_wsel = c8core_pkg::MW_REG;
        cmd_o.cnt_inc  = !sts_i.cnt_last;
      end
      c8core_pkg::S_LOAD_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.mem_asel = c8core_pkg::MA_IDX;
      end
      c8core_pkg::S_LOAD_WR: begin
        cmd_o.reg_wr   = 1'b1;
        cmd_o.reg_wsel = c8core_pkg::RW_LOAD;
        cmd_o.cnt_inc  = !sts_i.cnt_last;
      end
      c8core_pkg::S_TICK: cmd_o.tick = 1'b1;
      c8core_pkg::S_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c8core_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_run_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i == c8core_pkg::REQ_RUN) |=> state_q == c8core_pkg::S_FETCH_HI)
    else $error("run transaction did not start a fetch");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == c8core_pkg::S_DONE)
    else $error("result raised outside the done step");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == c8core_pkg::S_DONE && out_free) |=> (out_valid_q && in_ready_o))
    else $error("done step did not hand over its result");

endmodule

@@ sv/chip8_instruction_core_top.sv @@
// top level of the chip8 instruction core
//
// req_i takes one request per transaction: write a memory byte, read a
// memory byte, read one display pixel, or run one instruction cycle.
// rsp_o returns exactly one result per request, in order.
// cfg_i writes the font base register (index 1); index 0 holds the
// program start, which applies only at reset; it is always ready.
// A request is taken only while no earlier request is in progress.
// A run cycle fetches both opcode bytes, decodes and executes, then
// ticks the timers; flag setting arithmetic adds a write of VF, a
// sprite draw reads and writes back each drawn row and then writes VF,
// the decimal store writes its three digits one by one, and register
// save and load move one register at a time.
// The result waits in an output register; while rsp_o is stalled the
// next request is still taken and runs up to its final step.
// After reset the display and registers are clear, the program counter
// holds 512 and the font base is 80; main memory and the return stack
// hold nothing defined until written.
module chip8_instruction_core_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  c8core_req_if.sink         req_i,
  c8core_rsp_if.source       rsp_o,
  c8core_cfg_if.sink         cfg_i
);

  c8core_pkg::cmd_t cmd;
  c8core_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  c8core_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  c8core_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .address_i        (req_i.address),
    .write_byte_i     (req_i.write_byte),
    .keys_down_i      (req_i.keys_down),
    .random_byte_i    (req_i.random_byte),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .read_value_o     (rsp_o.read_value),
    .fetched_opcode_o (rsp_o.fetched_opcode),
    .next_pc_o        (rsp_o.next_pc),
    .sound_on_o       (rsp_o.sound_on),
    .waiting_key_o    (rsp_o.waiting_key)
  );

endmodule

@@ test/chip8_instruction_core_top_tb.sv @@
// self-checking testbench of the chip8 instruction core with a built-in behavioral predictor
module chip8_instruction_core_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_STALL_AT = 600;
  localparam int unsigned LONG_STALL = 400;
  localparam int unsigned PHASE_ITEMS = 390;

  typedef struct {
    c8core_pkg::req_e kind;
    logic [11:0]      addr;
    logic [7:0]       wbyte;
    logic [15:0]      keys;
    logic [7:0]       rnd;
    bit               drain;
  } chip_req_t;

  typedef struct {
    logic [7:0]  rv;
    logic [15:0] op;
    logic [11:0] pc;
    logic        snd;
    logic        wk;
  } chip_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  c8core_req_if req();
  c8core_rsp_if rsp();
  c8core_cfg_if cfg();

  chip8_instruction_core_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always #4 clk_i = ~clk_i;

  // shadow state of the core
  logic [7:0]  mem_m [c8core_pkg::MEM_DEPTH];
  bit          mem_ok [c8core_pkg::MEM_DEPTH];
  bit          pix_m [c8core_pkg::PIXELS];
  logic [7:0]  v_m [16];
  logic [11:0] stk_m [16];
  bit          stk_ok [16];
  logic [3:0]  sp_m;
  logic [11:0] pc_m;
  logic [15:0] ir_m;
  logic [7:0]  dly_m;
  logic [7:0]  snd_m;
  logic [11:0] font_m;

  chip_req_t req_queue[$];
  chip_rsp_t rsp_expect[$];
  int unsigned n_acc = 0;
  int unsigned n_recv = 0;
  int unsigned n_push = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycles = 0;
  bit          no_idle = 0;

  function automatic void draw_sprite(input int unsigned x0, input int unsigned y0,
                                      input int unsigned n);
    logic [7:0] bits;
    int unsigned p;
    v_m[c8core_pkg::REG_VF] = 8'd0;
    for (int unsigned row = 0; row < n; row++) begin
      if (y0 + row >= c8core_pkg::SCREEN_H) break;
      bits = mem_m[12'(ir_m + row)];
      for (int unsigned col = 0; col < 8; col++) begin
        if (x0 + col >= c8core_pkg::SCREEN_W) break;
        if (bits[7-col]) begin
          p = (y0 + row) * c8core_pkg::SCREEN_W + x0 + col;
          if (pix_m[p]) v_m[c8core_pkg::REG_VF] = 8'd1;
          pix_m[p] = ~pix_m[p];
        end
      end
    end
  endfunction

  function automatic void mem_put(input logic [11:0] a, input logic [7:0] v);
    mem_m[a] = v;
    mem_ok[a] = 1'b1;
  endfunction

  // one instruction; returns 1 when a key wait finds no key
  function automatic bit exec_op(input logic [15:0] op, input logic [15:0] keys);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic        f;
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    vx = v_m[x];
    vy = v_m[y];
    case (op[15:12])
      c8core_pkg::OP_SYS: begin
        if (op == c8core_pkg::OP_CLS) begin
          for (int k = 0; k < c8core_pkg::PIXELS; k++) pix_m[k] = 1'b0;
        end else if (op == c8core_pkg::OP_RET) begin
          sp_m = sp_m - 4'd1;
          pc_m = stk_m[sp_m];
        end
      end
      c8core_pkg::OP_JP: pc_m = op[11:0];
      c8core_pkg::OP_CALL: begin
        stk_m[sp_m] = pc_m;
        stk_ok[sp_m] = 1'b1;
        sp_m = sp_m + 4'd1;
        pc_m = op[11:0];
      end
      c8core_pkg::OP_SEK:  if (vx == kk) pc_m = pc_m + 12'd2;
      c8core_pkg::OP_SNEK: if (vx != kk) pc_m = pc_m + 12'd2;
      c8core_pkg::OP_SER:  if (vx == vy) pc_m = pc_m + 12'd2;
      c8core_pkg::OP_LDK:  v_m[x] = kk;
      c8core_pkg::OP_ADDK: v_m[x] = vx + kk;
      c8core_pkg::OP_ALU: begin
        case (op[3:0])
          c8core_pkg::ALU_MOV: v_m[x] = vy;
          c8core_pkg::ALU_OR:  v_m[x] = vx | vy;
          c8core_pkg::ALU_AND: v_m[x] = vx & vy;
          c8core_pkg::ALU_XOR: v_m[x] = vx ^ vy;
          c8core_pkg::ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            v_m[x] = sum[7:0];
            v_m[c8core_pkg::REG_VF] = {7'd0, sum[8]};
          end
          c8core_pkg::ALU_SUB: begin
            f = vx >= vy;
            v_m[x] = vx - vy;
            v_m[c8core_pkg::REG_VF] = {7'd0, f};
          end
          c8core_pkg::ALU_SHR: begin
            v_m[x] = vx >> 1;
            v_m[c8core_pkg::REG_VF] = {7'd0, vx[0]};
          end
          c8core_pkg::ALU_SBN: begin
            f = vy >= vx;
            v_m[x] = vy - vx;
            v_m[c8core_pkg::REG_VF] = {7'd0, f};
          end
          c8core_pkg::ALU_SHL: begin
            v_m[x] = vx << 1;
            v_m[c8core_pkg::REG_VF] = {7'd0, vx[7]};
          end
          default: ;
        endcase
      end
      c8core_pkg::OP_SNER: if (vx != vy) pc_m = pc_m + 12'd2;
      c8core_pkg::OP_LDI:  ir_m = {4'd0, op[11:0]};
      c8core_pkg::OP_JPV0: pc_m = op[11:0] + {4'd0, v_m[0]};
      c8core_pkg::OP_DRW:
        draw_sprite(vx % c8core_pkg::SCREEN_W, vy % c8core_pkg::SCREEN_H, op[3:0]);
      c8core_pkg::OP_KEY: begin
        if (kk == c8core_pkg::KEY_SKP && keys[vx[3:0]]) pc_m = pc_m + 12'd2;
        else if (kk == c8core_pkg::KEY_SKNP && !keys[vx[3:0]]) pc_m = pc_m + 12'd2;
      end
      c8core_pkg::OP_MISC: begin
        case (kk)
          c8core_pkg::MISC_GDLY: v_m[x] = dly_m;
          c8core_pkg::MISC_WKEY: begin
            for (int k = 0; k < 16; k++) begin
              if (keys[k]) begin
                v_m[x] = 8'(k);
                return 1'b0;
              end
            end
            pc_m = pc_m - 12'd2;
            return 1'b1;
          end
          c8core_pkg::MISC_SDLY: dly_m = vx;
          c8core_pkg::MISC_SSND: snd_m = vx;
          c8core_pkg::MISC_ADDI: ir_m = ir_m + {8'd0, vx};
          c8core_pkg::MISC_FONT: ir_m = {4'd0, font_m} + 16'(5 * vx);
          c8core_pkg::MISC_BCD: begin
            mem_put(12'(ir_m), vx / 8'd100);
            mem_put(12'(ir_m + 16'd1), (vx / 8'd10) % 8'd10);
            mem_put(12'(ir_m + 16'd2), vx % 8'd10);
          end
          c8core_pkg::MISC_STR:
            for (int k = 0; k <= x; k++) mem_put(12'(ir_m + 16'(k)), v_m[k]);
          c8core_pkg::MISC_LDR:
            for (int k = 0; k <= x; k++) v_m[k] = mem_m[12'(ir_m + 16'(k))];
          default: ;
        endcase
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic chip_rsp_t chip8_predict(input chip_req_t it);
    chip_rsp_t r;
    r = '{rv: 8'd0, op: 16'd0, pc: 12'd0, snd: 1'b0, wk: 1'b0};
    case (it.kind)
      c8core_pkg::REQ_WRITE: mem_put(it.addr, it.wbyte);
      c8core_pkg::REQ_READ:  r.rv = mem_m[it.addr];
      c8core_pkg::REQ_PIXEL:
        r.rv = (it.addr < c8core_pkg::PIXELS) ? {7'd0, pix_m[it.addr]} : 8'd0;
      default: begin
        r.op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
        pc_m = pc_m + 12'd2;
        if (r.op[15:12] == c8core_pkg::OP_RND) v_m[r.op[11:8]] = it.rnd & r.op[7:0];
        else r.wk = exec_op(r.op, it.keys);
        if (dly_m != 0) dly_m = dly_m - 8'd1;
        if (snd_m != 0) snd_m = snd_m - 8'd1;
      end
    endcase
    r.pc = pc_m;
    r.snd = snd_m != 0;
    return r;
  endfunction

  function automatic logic [15:0] rand_keys();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0001 << $urandom_range(0, 15);
      2: return 16'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly meaningful opcodes with random operands
  function automatic logic [15:0] rand_op();
    logic [3:0]  g;
    logic [11:0] low;
    logic [3:0]  alu_ops [9];
    logic [7:0]  misc_ops [9];
    alu_ops = '{c8core_pkg::ALU_MOV, c8core_pkg::ALU_OR, c8core_pkg::ALU_AND,
                c8core_pkg::ALU_XOR, c8core_pkg::ALU_ADD, c8core_pkg::ALU_SUB,
                c8core_pkg::ALU_SHR, c8core_pkg::ALU_SBN, c8core_pkg::ALU_SHL};
    misc_ops = '{c8core_pkg::MISC_GDLY, c8core_pkg::MISC_WKEY, c8core_pkg::MISC_SDLY,
                 c8core_pkg::MISC_SSND, c8core_pkg::MISC_ADDI, c8core_pkg::MISC_FONT,
                 c8core_pkg::MISC_BCD, c8core_pkg::MISC_STR, c8core_pkg::MISC_LDR};
    g = 4'($urandom);
    low = 12'($urandom);
    case (g)
      c8core_pkg::OP_SYS: begin
        case ($urandom_range(0, 3))
          0: return c8core_pkg::OP_CLS;
          1, 2: return c8core_pkg::OP_RET;
          default: return {c8core_pkg::OP_SYS, low};
        endcase
      end
      c8core_pkg::OP_ALU:
        if ($urandom_range(0, 7) != 0) low[3:0] = alu_ops[$urandom_range(0, 8)];
      c8core_pkg::OP_KEY: begin
        case ($urandom_range(0, 4))
          0, 1: low[7:0] = c8core_pkg::KEY_SKP;
          2, 3: low[7:0] = c8core_pkg::KEY_SKNP;
          default: ;
        endcase
      end
      c8core_pkg::OP_MISC:
        if ($urandom_range(0, 9) != 0) low[7:0] = misc_ops[$urandom_range(0, 8)];
      default: ;
    endcase
    return {g, low};
  endfunction

  task automatic push_item(input chip_req_t it);
    while (req_queue.size() > 16) @(posedge clk_i);
    rsp_expect.push_back(chip8_predict(it));
    req_queue.push_back(it);
    n_push++;
  endtask

  task automatic push_simple(input c8core_pkg::req_e kind, input logic [11:0] addr,
                             input logic [7:0] wbyte);
    chip_req_t it;
    it = '{kind: kind, addr: addr, wbyte: wbyte, keys: 16'($urandom),
           rnd: 8'($urandom), drain: 0};
    push_item(it);
  endtask

  // give a never-written byte a value before the core reads it
  task automatic fill_byte(input logic [11:0] a);
    if (!mem_ok[a]) push_simple(c8core_pkg::REQ_WRITE, a, 8'($urandom));
  endtask

  task automatic push_read(input logic [11:0] addr, input bit drain);
    chip_req_t it;
    fill_byte(addr);
    it = '{kind: c8core_pkg::REQ_READ, addr: addr, wbyte: 8'($urandom),
           keys: 16'($urandom), rnd: 8'($urandom), drain: drain};
    push_item(it);
  endtask

  // run one cycle; unwritten code and data get values first, and a return
  // through a never-written stack slot is patched away
  task automatic issue_run(input logic [15:0] keys, input logic [7:0] rnd);
    chip_req_t   it;
    logic [15:0] op;
    logic [11:0] pc1;
    pc1 = pc_m + 12'd1;
    if (!mem_ok[pc_m] || !mem_ok[pc1]) begin
      op = rand_op();
      push_simple(c8core_pkg::REQ_WRITE, pc_m, op[15:8]);
      push_simple(c8core_pkg::REQ_WRITE, pc1, op[7:0]);
    end
    op = {mem_m[pc_m], mem_m[pc1]};
    if (op == c8core_pkg::OP_RET && !stk_ok[sp_m - 4'd1]) begin
      push_simple(c8core_pkg::REQ_WRITE, pc1, c8core_pkg::OP_CLS[7:0]);
      op = c8core_pkg::OP_CLS;
    end
    if (op[15:12] == c8core_pkg::OP_DRW) begin
      for (int unsigned r = 0; r < op[3:0]; r++) fill_byte(12'(ir_m + 16'(r)));
    end
    if (op[15:12] == c8core_pkg::OP_MISC && op[7:0] == c8core_pkg::MISC_LDR) begin
      for (int unsigned k = 0; k <= op[11:8]; k++) fill_byte(12'(ir_m + 16'(k)));
    end
    it = '{kind: c8core_pkg::REQ_RUN, addr: 12'($urandom), wbyte: 8'($urandom),
           keys: keys, rnd: rnd, drain: $urandom_range(0, 99) == 0};
    push_item(it);
  endtask

  task automatic put_run(input logic [15:0] op, input logic [15:0] keys);
    push_simple(c8core_pkg::REQ_WRITE, pc_m, op[15:8]);
    push_simple(c8core_pkg::REQ_WRITE, pc_m + 12'd1, op[7:0]);
    issue_run(keys, 8'($urandom));
  endtask

  task automatic wait_idle();
    while (req_queue.size() != 0 || n_acc != n_recv || req.valid) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [c8core_pkg::CFG_IW-1:0] idx,
                           input logic [11:0] data);
    wait_idle();
    cfg.index <= idx;
    cfg.data <= data;
    cfg.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == c8core_pkg::CFG_FONT) font_m = data;
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    stop = n_push + n;
    while (n_push < stop) begin
      case ($urandom_range(0, 19))
        0, 1: push_simple(c8core_pkg::REQ_WRITE, 12'($urandom), 8'($urandom));
        2, 3: push_read(12'($urandom), 1'b0);
        4, 5: push_simple(c8core_pkg::REQ_PIXEL, 12'($urandom), 8'($urandom));
        6, 7, 8: put_run(rand_op(), rand_keys());
        default: issue_run(rand_keys(), 8'($urandom));
      endcase
    end
    // hold the sender until the core has drained
    push_read(12'($urandom), 1'b1);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    chip_req_t it;
    static int unsigned gap_left = 0;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.req_type <= c8core_pkg::REQ_WRITE;
      req.address <= '0;
      req.write_byte <= '0;
      req.keys_down <= '0;
      req.random_byte <= '0;
      gap_left = 0;
    end else begin
      if (req.valid && req.ready) n_acc <= n_acc + 1;
      if (!req.valid || req.ready) begin
        if (gap_left != 0) begin
          req.valid <= 1'b0;
          gap_left--;
        end else if (req_queue.size() != 0 &&
                     (!req_queue[0].drain || (!req.valid && n_acc == n_recv))) begin
          it = req_queue.pop_front();
          req.req_type <= it.kind;
          req.address <= it.addr;
          req.write_byte <= it.wbyte;
          req.keys_down <= it.keys;
          req.random_byte <= it.rnd;
          req.valid <= 1'b1;
          gap_left = no_idle ? 0 : $urandom_range(0, 15);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    chip_rsp_t e;
    int unsigned s;
    static int unsigned stall_left = 0;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else begin
      s = stall_left;
      if (rsp.valid && rsp.ready) begin
        n_recv <= n_recv + 1;
        if (rsp_expect.size() == 0) begin
          $error("result with no expectation waiting");
          fail_cnt++;
        end else begin
          e = rsp_expect.pop_front();
          if (rsp.read_value !== e.rv) begin
            $error("read_value expected %0h got %0h", e.rv, rsp.read_value);
            fail_cnt++;
          end
          if (rsp.fetched_opcode !== e.op) begin
            $error("fetched_opcode expected %0h got %0h", e.op, rsp.fetched_opcode);
            fail_cnt++;
          end
          if (rsp.next_pc !== e.pc) begin
            $error("next_pc expected %0h got %0h", e.pc, rsp.next_pc);
            fail_cnt++;
          end
          if (rsp.sound_on !== e.snd) begin
            $error("sound_on expected %0b got %0b", e.snd, rsp.sound_on);
            fail_cnt++;
          end
          if (rsp.waiting_key !== e.wk) begin
            $error("waiting_key expected %0b got %0b", e.wk, rsp.waiting_key);
            fail_cnt++;
          end
        end
        s = no_idle ? 0 : $urandom_range(0, 15);
        // long hold-off so the core fills up and backs up its input
        if (n_recv == LONG_STALL_AT) s = LONG_STALL;
      end
      if (s != 0) begin
        rsp.ready <= 1'b0;
        stall_left = s - 1;
      end else begin
        rsp.ready <= 1'b1;
        stall_left = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL chip8_instruction_core_top");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = c8core_pkg::CFG_START;
    cfg.data = '0;
    for (int k = 0; k < c8core_pkg::MEM_DEPTH; k++) begin
      mem_m[k] = 8'd0;
      mem_ok[k] = 1'b0;
    end
    for (int k = 0; k < c8core_pkg::PIXELS; k++) pix_m[k] = 1'b0;
    for (int k = 0; k < 16; k++) begin
      v_m[k] = 8'd0;
      stk_m[k] = 12'd0;
      stk_ok[k] = 1'b0;
    end
    sp_m = 4'd0;
    pc_m = c8core_pkg::PC_RST;
    ir_m = 16'd0;
    dly_m = 8'd0;
    snd_m = 8'd0;
    font_m = c8core_pkg::FONT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // program start only acts at reset, so this write leaves the counter alone
    cfg_write(c8core_pkg::CFG_START, 12'd0);

    // directed: field extremes, flags, clipping, stack, keys, store and load
    push_simple(c8core_pkg::REQ_WRITE, 12'hFFF, 8'hFF);
    push_read(12'hFFF, 1'b0);
    push_read(12'h000, 1'b0);
    push_simple(c8core_pkg::REQ_PIXEL, 12'd2047, 8'h00);
    push_simple(c8core_pkg::REQ_PIXEL, 12'd2048, 8'h00);
    put_run(16'h60FF, 16'h0000);
    put_run(16'h6101, 16'h0000);
    put_run(16'h8014, 16'h0000);
    put_run(16'h6F80, 16'h0000);
    put_run(16'h8FF4, 16'h0000);
    put_run(16'h8015, 16'h0000);
    put_run(16'h8017, 16'h0000);
    put_run(16'h6081, 16'h0000);
    put_run(16'h8016, 16'h0000);
    put_run(16'h801E, 16'h0000);
    put_run(16'h6A3F, 16'h0000);
    put_run(16'h6B1F, 16'h0000);
    put_run(16'hA800, 16'h0000);
    put_run(16'hDABF, 16'h0000);
    push_simple(c8core_pkg::REQ_PIXEL, 12'd2047, 8'h00);
    put_run(16'hDAB0, 16'h0000);
    put_run(16'h00E0, 16'h0000);
    put_run(16'h2A00, 16'h0000);
    put_run(c8core_pkg::OP_RET, 16'h0000);
    put_run(16'hF00A, 16'h0000);
    issue_run(16'h8000, 8'h00);
    put_run(16'hE09E, 16'h8000);
    put_run(16'hE0A1, 16'h0000);
    put_run(16'hFF55, 16'h0000);
    put_run(16'hFF65, 16'h0000);
    put_run(16'hF033, 16'h0000);
    put_run(16'hBFFF, 16'h0000);
    put_run(16'h6005, 16'h0000);
    put_run(16'hF018, 16'h0000);
    put_run(16'hF015, 16'h0000);
    put_run(16'hF007, 16'h0000);
    put_run(16'hF029, 16'h0000);
    put_run(16'hF01E, 16'h0000);
    put_run(16'h5011, 16'h0000);
    put_run(16'h801F, 16'h0000);
    put_run(16'hE000, 16'h0000);
    put_run(16'hF0FF, 16'h0000);
    put_run(16'hC0FF, 16'h0000);

    random_phase(PHASE_ITEMS);
    cfg_write(c8core_pkg::CFG_FONT, 12'd0);
    cfg_write(c8core_pkg::CFG_START, 12'hFFF);
    random_phase(PHASE_ITEMS);
    cfg_write(c8core_pkg::CFG_FONT, 12'hFFF);
    no_idle = 1;
    random_phase(PHASE_ITEMS);
    no_idle = 0;
    cfg_write(c8core_pkg::CFG_FONT, 12'($urandom));
    random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && rsp_expect.size() == 0) begin
      $display("PASS chip8_instruction_core_top");
    end else begin
      $display("FAIL chip8_instruction_core_top");
    end
    $finish;
  end

endmodule
